/* src/kmhid_pkg.sv */
// Shared types and constants for the key matrix HID report builder.
// No dependencies; imported by every module of the block.
`default_nettype none

package kmhid_pkg;

  localparam int ROWS       = 8;
  localparam int COLS       = 16;
  localparam int KEY_SLOTS  = 6;
  localparam int MAX_SLOTS  = 6;
  localparam int SLOT_IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] USAGE_NONE     = 8'h00;
  localparam logic [7:0] USAGE_ROLLOVER = 8'h01;

  localparam int APB_AW = 3;
  localparam logic REG_OVERFLOW_CODE = 1'b0;

  typedef struct packed {
    logic [2:0] row;
    logic [3:0] col;
    logic       closed;
    logic [7:0] usage;
    logic [7:0] mod_bits;
    logic       row_end;
  } in_t;

  typedef struct packed {
    logic [7:0] modifiers;
    logic [7:0] slot_0;
    logic [7:0] slot_1;
    logic [7:0] slot_2;
    logic [7:0] slot_3;
    logic [7:0] slot_4;
    logic [7:0] slot_5;
  } out_t;

  typedef enum logic [1:0] {
    EDGE_NONE    = 2'd0,
    EDGE_PRESS   = 2'd1,
    EDGE_RELEASE = 2'd2
  } edge_kind_e;

  typedef struct packed {
    edge_kind_e kind;
    logic [7:0] code;
    logic [7:0] mask;
    logic       row_end;
  } cmd_t;

endpackage

`default_nettype wire

/* src/kmhid_front.sv */
// Front end: accepts key samples, tracks the pressed bitmap and classifies edges.
// Depends on kmhid_pkg; feeds edge commands to kmhid_fifo.
`default_nettype none

module kmhid_front
  import kmhid_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_i,
  output logic      push_o,
  output cmd_t      cmd_o,
  input  wire logic full_i
);

  logic [COLS-1:0] pressed_q [ROWS];
  logic            accept;
  logic            in_range;
  logic            was;
  edge_kind_e      kind;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign in_range   = ({1'b0, in_i.row} < 4'(ROWS)) && ({1'b0, in_i.col} < 5'(COLS));
  assign was        = pressed_q[in_i.row][in_i.col];

  always_comb begin
    kind = EDGE_NONE;
    if (in_range) begin
      if (in_i.closed && !was) begin
        kind = EDGE_PRESS;
      end else if (!in_i.closed && was) begin
        kind = EDGE_RELEASE;
      end
    end
  end

  assign push_o        = accept && ((kind != EDGE_NONE) || in_i.row_end);
  assign cmd_o.kind    = kind;
  assign cmd_o.code    = in_i.usage;
  assign cmd_o.mask    = in_i.mod_bits;
  assign cmd_o.row_end = in_i.row_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        pressed_q[r] <= '0;
      end
    end else if (accept && (kind != EDGE_NONE)) begin
      pressed_q[in_i.row][in_i.col] <= (kind == EDGE_PRESS);
    end
  end

endmodule

`default_nettype wire

/* src/kmhid_fifo.sv */
// Short command queue between the front end and the report back end.
// Depends on kmhid_pkg for cmd_t and the queue depth.
`default_nettype none

module kmhid_fifo
  import kmhid_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  output logic      full_o,
  output logic      valid_o,
  output cmd_t      cmd_o,
  input  wire logic pop_i
);

  cmd_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

/* src/kmhid_back.sv */
// Back end: applies edge commands to the slots and modifier byte, emits reports.
// Depends on kmhid_pkg; pops commands from kmhid_fifo.
`default_nettype none

module kmhid_back
  import kmhid_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cmd_valid_i,
  input  wire cmd_t       cmd_i,
  output logic            pop_o,
  input  wire logic [7:0] overflow_code_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output out_t            out_o
);

  logic [7:0]            slots_q [MAX_SLOTS];
  logic [7:0]            slots_d [MAX_SLOTS];
  logic [7:0]            mods_q, mods_d;
  logic                  ovf_q, ovf_d;
  logic                  chg_q, chg_d;
  logic                  out_valid_q;
  out_t                  out_q;
  logic [KEY_SLOTS-1:0]  hit, free;
  logic [SLOT_IDX_W-1:0] free_idx;
  logic [7:0]            slot_val [MAX_SLOTS];
  logic                  emit;
  logic                  dup;

  always_comb begin
    for (int s = 0; s < MAX_SLOTS; s++) begin
      slots_d[s] = slots_q[s];
    end
    mods_d   = mods_q;
    ovf_d    = ovf_q;
    chg_d    = chg_q;
    free_idx = '0;
    for (int s = 0; s < KEY_SLOTS; s++) begin
      hit[s]  = (slots_q[s] == cmd_i.code);
      free[s] = (slots_q[s] == USAGE_NONE);
      if (free[s]) begin
        free_idx = SLOT_IDX_W'(s);
      end
    end
    case (cmd_i.kind)
      EDGE_PRESS: begin
        mods_d = mods_q | cmd_i.mask;
        chg_d  = 1'b1;
        if ((cmd_i.code != USAGE_NONE) && !(|hit)) begin
          if (|free) begin
            slots_d[free_idx] = cmd_i.code;
          end else begin
            ovf_d = 1'b1;
          end
        end
      end
      EDGE_RELEASE: begin
        mods_d = mods_q & ~cmd_i.mask;
        chg_d  = 1'b1;
        if (cmd_i.code != USAGE_NONE) begin
          for (int s = 0; s < KEY_SLOTS; s++) begin
            if (hit[s]) begin
              slots_d[s] = USAGE_NONE;
            end
          end
          if (|hit) begin
            ovf_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
    for (int s = 0; s < MAX_SLOTS; s++) begin
      if (s < KEY_SLOTS) begin
        slot_val[s] = ovf_d ? overflow_code_i : slots_d[s];
      end else begin
        slot_val[s] = USAGE_NONE;
      end
    end
  end

  assign emit  = cmd_i.row_end && chg_d;
  assign pop_o = cmd_valid_i && (!emit || !out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < MAX_SLOTS; s++) begin
        slots_q[s] <= USAGE_NONE;
      end
      mods_q      <= '0;
      ovf_q       <= 1'b0;
      chg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        for (int s = 0; s < MAX_SLOTS; s++) begin
          slots_q[s] <= slots_d[s];
        end
        mods_q <= mods_d;
        ovf_q  <= ovf_d;
        chg_q  <= chg_d && !emit;
      end
      if (pop_o && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      out_q.modifiers <= mods_d;
      out_q.slot_0    <= slot_val[0];
      out_q.slot_1    <= slot_val[1];
      out_q.slot_2    <= slot_val[2];
      out_q.slot_3    <= slot_val[3];
      out_q.slot_4    <= slot_val[4];
      out_q.slot_5    <= slot_val[5];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    dup = 1'b0;
    for (int a = 0; a < KEY_SLOTS; a++) begin
      for (int b = a + 1; b < KEY_SLOTS; b++) begin
        if ((slots_q[a] != USAGE_NONE) && (slots_q[a] == slots_q[b])) begin
          dup = 1'b1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> !(|free))
    else $error("overflow set while a slot is free");

  a_no_dup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !dup)
    else $error("duplicate key code in slots");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && emit) |=> (!chg_q && out_valid_q))
    else $error("emitted report did not clear changed mark");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_i && emit && out_valid_q && !out_ready_i) |-> !pop_o)
    else $error("command retired over a pending report");
`endif

endmodule

`default_nettype wire

/* src/key_matrix_hid_report_builder.sv */
// Top level of the key matrix HID report builder: APB register and the
// front end, command queue and back end. Depends on kmhid_pkg and all kmhid_* modules.
//
// Takes one matrix key sample per transfer and emits a 6-key boot keyboard
// report on the sample that ends a row whenever any key edge occurred since
// the last report. An input transfer is taken every cycle while the
// two-entry command queue has room; the back end retires one command per
// cycle unless halted, so sustained throughput is one sample per clock. The back
// end halts only on a row end that must emit while the previous report still waits
// in the output register; the queue then fills and in_ready_o drops. Samples
// with no edge and no row end never enter the queue. Register 0 at byte
// address 0 holds the code reported in all slots while in overflow (reset 1).
`default_nettype none

module key_matrix_hid_report_builder
  import kmhid_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire in_t               in_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output out_t                   out_o,
  input  wire logic              psel_i,
  input  wire logic              penable_i,
  input  wire logic              pwrite_i,
  input  wire logic [APB_AW-1:0] paddr_i,
  input  wire logic [31:0]       pwdata_i,
  output logic [31:0]            prdata_o,
  output logic                   pready_o
);

  logic [7:0] overflow_code_q;
  logic       push, full, cmd_valid, pop;
  cmd_t       cmd_in, cmd_out;

  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[2] == REG_OVERFLOW_CODE) ? {24'h0, overflow_code_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      overflow_code_q <= USAGE_ROLLOVER;
    end else if (psel_i && penable_i && pwrite_i && pready_o &&
                 (paddr_i[2] == REG_OVERFLOW_CODE)) begin
      overflow_code_q <= pwdata_i[7:0];
    end
  end

  kmhid_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .push_o     (push),
    .cmd_o      (cmd_in),
    .full_i     (full)
  );

  kmhid_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .valid_o (cmd_valid),
    .cmd_o   (cmd_out),
    .pop_i   (pop)
  );

  kmhid_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd_out),
    .pop_o           (pop),
    .overflow_code_i (overflow_code_q),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_o           (out_o)
  );

endmodule

`default_nettype wire
